/* rtl/krt_pkg.sv */
// ----------------------------------------------------------------------------
// krt_pkg
// shared types and codes for the keyed record table
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int RecWidth = 66;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_SORT   = 2'd2,
      REQ_READ   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_DUP      = 3'd1,
      ST_FULL     = 3'd2,
      ST_DELETED  = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_SORTED   = 3'd5,
      ST_READOK   = 3'd6,
      ST_BADPOS   = 3'd7
   } status_code_type;

   localparam logic [1:0] KindOther = 2'd2;

   typedef struct packed {
      logic [15:0] game_name_ref;
      logic [15:0] item_name_ref;
      logic [1:0]  kind;
      logic [31:0] key;
   } record_type;

endpackage

/* rtl/krt_ram.sv */
// ----------------------------------------------------------------------------
// krt_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module krt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/keyed_record_table.sv */
// ----------------------------------------------------------------------------
// keyed_record_table
// bounded ordered record table with add, delete, sort and read
// ----------------------------------------------------------------------------
// Records live in one ram with a registered read. A sequencer reads
// an entry, compares or moves it, and writes it back, one entry at a time.
// Items are handled one at a time. A new item is accepted only when the
// sequencer is idle and the output register is empty or is being emptied, so
// a result that waits on rsp_tready holds off the input. Full and bad-position
// replies are presented at the accepting edge; read fetches the entry at the
// given position; add and delete scan the entries in order for the key, and
// a delete then shifts each later entry down one slot; sort runs bubble
// passes that compare each adjacent pair and swap it when out of order.
module keyed_record_table #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_type[1:0], item_key[33:2], item_kind[35:34], item_name_ref[51:36],
   // game_name_ref[67:52], position[71:68]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], out_key[34:3], out_kind[36:35], out_item_name_ref[52:37],
   // out_game_name_ref[68:53], entry_count[73:69]
   output logic [79:0] rsp_tdata
);
   import krt_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_RD    = 8'b00000010,
      S_CHK   = 8'b00000100,
      S_SHRD  = 8'b00001000,
      S_SHWR  = 8'b00010000,
      S_SRD   = 8'b00100000,
      S_SCMP  = 8'b01000000,
      S_DONE  = 8'b10000000
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pass_ff, pass_in;
   req_code_type  op_ff, op_in;
   logic [31:0]   key_ff, key_in;
   record_type    new_ff, new_in;
   record_type    hold_ff, hold_in;
   logic          out_v_ff, out_v_in;
   logic [73:0]   out_ff, out_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   record_type    wr_data, rd_data;
   logic          accept;
   logic [73:0]   result;
   logic          emit;

   krt_ram #(.Width(RecWidth), .Depth(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign req_tready = (state_ff == S_IDLE) && (!out_v_ff || rsp_tready);
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {6'd0, out_ff};

   function automatic logic [73:0] pack(input status_code_type st,
                                        input record_type r,
                                        input logic [CW-1:0] cnt);
      logic [CW+4:0] wide;
      wide = {5'd0, cnt};
      return {wide[4:0], r.game_name_ref, r.item_name_ref, r.kind, r.key, st};
   endfunction

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      idx_in = idx_ff;
      pass_in = pass_ff;
      op_in = op_ff;
      key_in = key_ff;
      new_in = new_ff;
      hold_in = hold_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      result = '0;
      emit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_code_type'(req_tdata[1:0]);
               key_in = req_tdata[33:2];
               new_in.key = req_tdata[33:2];
               new_in.kind = (req_tdata[35:34] == 2'd3) ? KindOther : req_tdata[35:34];
               new_in.item_name_ref = req_tdata[51:36];
               new_in.game_name_ref = req_tdata[67:52];
               idx_in = '0;
               pass_in = '0;
               unique case (req_code_type'(req_tdata[1:0]))
                  REQ_ADD: begin
                     if (fill_ff >= CW'(CAPACITY)) begin
                        result = pack(ST_FULL, '0, fill_ff);
                        emit = 1'b1;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  REQ_DELETE: state_in = S_RD;
                  REQ_SORT:   state_in = S_SRD;
                  REQ_READ: begin
                     if ({{CW{1'b0}}, req_tdata[71:68]} < {4'd0, fill_ff}) begin
                        idx_in = CW'(req_tdata[71:68]);
                        state_in = S_RD;
                     end else begin
                        result = pack(ST_BADPOS, '0, fill_ff);
                        emit = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            if (op_ff != REQ_READ && idx_ff >= fill_ff) begin
               if (op_ff == REQ_ADD) begin
                  wr_en = 1'b1;
                  wr_addr = fill_ff[AW-1:0];
                  wr_data = new_ff;
                  fill_in = fill_ff + 1'b1;
                  result = pack(ST_ADDED, '0, fill_ff + 1'b1);
               end else begin
                  result = pack(ST_NOTFOUND, '0, fill_ff);
               end
               emit = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (op_ff == REQ_READ) begin
               result = pack(ST_READOK, rd_data, fill_ff);
               emit = 1'b1;
               state_in = S_IDLE;
            end else if (rd_data.key == key_ff) begin
               if (op_ff == REQ_ADD) begin
                  result = pack(ST_DUP, '0, fill_ff);
                  emit = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SHRD;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_SHRD: begin
            if (idx_ff + 1'b1 >= fill_ff) begin
               fill_in = fill_ff - 1'b1;
               result = pack(ST_DELETED, '0, fill_ff - 1'b1);
               emit = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_addr = AW'(idx_ff + 1'b1);
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            wr_en = 1'b1;
            if (op_ff == REQ_SORT) begin
               // second half of a swap: held record goes one slot up
               wr_data = new_ff;
               state_in = S_SRD;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SHRD;
            end
         end
         S_SRD: begin
            // read entry idx, hold it, then read idx+1 next
            if (pass_ff >= fill_ff || idx_ff + 1'b1 >= fill_ff) begin
               if (pass_ff + 1'b1 >= fill_ff) begin
                  result = pack(ST_SORTED, '0, fill_ff);
                  emit = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  pass_in = pass_ff + 1'b1;
                  idx_in = '0;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            hold_in = rd_data;
            rd_addr = AW'(idx_ff + 1'b1);
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (hold_ff.key > rd_data.key) begin
               // smaller record moves down now
               wr_en = 1'b1;
               wr_data = rd_data;
               new_in = hold_ff;
               idx_in = idx_ff + 1'b1;
               state_in = S_SHWR;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_v_in = out_v_ff;
      out_in = out_ff;
      if (out_v_ff && rsp_tready) out_v_in = 1'b0;
      if (emit) begin
         out_v_in = 1'b1;
         out_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         out_v_ff <= out_v_in;
      end
      idx_ff <= idx_in;
      pass_ff <= pass_in;
      op_ff <= op_in;
      key_ff <= key_in;
      new_ff <= new_in;
      hold_ff <= hold_in;
      out_ff <= out_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY)) else $error("fill count beyond capacity");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!out_v_ff || rsp_tready)) else $error("result overwritten");
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped");
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the keyed record table: a shadow table predicts status, read data
// and fill count for every item, and results are compared in order
// ----------------------------------------------------------------------------
module tb_top;
   import krt_pkg::*;

   localparam int Cap = 16;

   typedef struct packed {
      logic [3:0]  position;
      logic [15:0] game_name_ref;
      logic [15:0] item_name_ref;
      logic [1:0]  item_kind;
      logic [31:0] item_key;
      req_code_type req_type;
   } req_item_type;

   typedef struct packed {
      logic [4:0]  entry_count;
      logic [15:0] game_name_ref;
      logic [15:0] item_name_ref;
      logic [1:0]  kind;
      logic [31:0] key;
      status_code_type status;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   keyed_record_table #(.CAPACITY(Cap)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   record_type   shadow_table[Cap];
   int           shadow_fill = 0;
   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int           error_count = 0;
   int           req_gap = 0;
   int           rsp_gap = 0;
   int           hold_off = 0;
   bit           stim_done = 1'b0;
   bit           drain_pause = 1'b0;
   int           idle_cycles = 0;
   int           rsp_total = 0;
   int           status_seen[8];
   logic [31:0]  added_keys[$];

   function automatic rsp_item_type predict_table(req_item_type r);
      rsp_item_type o;
      int where;
      record_type tmp;
      o = '0;
      where = -1;
      for (int i = 0; i < shadow_fill; i++)
         if (where < 0 && shadow_table[i].key == r.item_key) where = i;
      case (r.req_type)
         REQ_ADD: begin
            if (shadow_fill >= Cap) o.status = ST_FULL;
            else if (where >= 0) o.status = ST_DUP;
            else begin
               shadow_table[shadow_fill].key = r.item_key;
               shadow_table[shadow_fill].kind = (r.item_kind > KindOther) ? KindOther
                                                                         : r.item_kind;
               shadow_table[shadow_fill].item_name_ref = r.item_name_ref;
               shadow_table[shadow_fill].game_name_ref = r.game_name_ref;
               shadow_fill++;
               o.status = ST_ADDED;
            end
         end
         REQ_DELETE: begin
            if (where >= 0) begin
               for (int i = where; i + 1 < shadow_fill; i++)
                  shadow_table[i] = shadow_table[i + 1];
               shadow_fill--;
               o.status = ST_DELETED;
            end else o.status = ST_NOTFOUND;
         end
         REQ_SORT: begin
            for (int i = 0; i < shadow_fill; i++)
               for (int j = 0; j + 1 < shadow_fill; j++)
                  if (shadow_table[j].key > shadow_table[j + 1].key) begin
                     tmp = shadow_table[j];
                     shadow_table[j] = shadow_table[j + 1];
                     shadow_table[j + 1] = tmp;
                  end
            o.status = ST_SORTED;
         end
         default: begin
            if (r.position < shadow_fill) begin
               o.status = ST_READOK;
               o.key = shadow_table[r.position].key;
               o.kind = shadow_table[r.position].kind;
               o.item_name_ref = shadow_table[r.position].item_name_ref;
               o.game_name_ref = shadow_table[r.position].game_name_ref;
            end else o.status = ST_BADPOS;
         end
      endcase
      o.entry_count = shadow_fill[4:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_item_type make_req(req_code_type t, logic [31:0] k,
                                             logic [3:0] p);
      req_item_type r;
      r.req_type = t;
      r.item_key = k;
      r.item_kind = 2'($urandom_range(0, 3));
      r.item_name_ref = 16'($urandom);
      r.game_name_ref = 16'($urandom);
      r.position = p;
      return r;
   endfunction

   function automatic logic [31:0] pick_key(int pool);
      if (added_keys.size() > 0 && $urandom_range(0, 99) < 55)
         return added_keys[$urandom_range(0, added_keys.size() - 1)];
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, pool);
   endfunction

   // driver
   always @(posedge clock) begin
      req_item_type r;
      if (!reset) begin
         if (!(req_tvalid && !req_tready)) begin
            if (req_tvalid) req_gap = pick_gap();
            else if (req_gap > 0) req_gap--;
            if (req_gap == 0 && !drain_pause && pending_reqs.size() > 0) begin
               r = pending_reqs.pop_front();
               req_tdata <= r;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // accepted items go through the predictor at the handshake
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         expected_rsps.push_back(predict_table(req_item_type'(req_tdata)));
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_item_type'(rsp_tdata[73:0]);
            rsp_total++;
            status_seen[got.status]++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected item", got.status, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status) report_mismatch("status", got.status, want.status);
               if (got.key !== want.key) report_mismatch("key", got.key, want.key);
               if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
               if (got.item_name_ref !== want.item_name_ref)
                  report_mismatch("item name", got.item_name_ref, want.item_name_ref);
               if (got.game_name_ref !== want.game_name_ref)
                  report_mismatch("game name", got.game_name_ref, want.game_name_ref);
               if (got.entry_count !== want.entry_count)
                  report_mismatch("count", got.entry_count, want.entry_count);
            end
            if (rsp_tdata[79:74] !== '0) report_mismatch("pad", rsp_tdata[79:74], 0);
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready) rsp_gap = pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset
          || hold_off > 0 || stim_done)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("watchdog expired");
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_item_type r;
      int wait_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-table cases, fill past full, kind three, reads
      pending_reqs.push_back(make_req(REQ_DELETE, 32'h0, 4'd0));
      pending_reqs.push_back(make_req(REQ_READ, 32'h0, 4'd0));
      pending_reqs.push_back(make_req(REQ_SORT, 32'h0, 4'd0));
      for (int i = 0; i < 17; i++) begin
         r = make_req(REQ_ADD, (i == 0) ? 32'hFFFF_FFFF : 32'd100 - i * 5, 4'd0);
         if (i == 1) begin
            r.item_kind = 2'd3;
            r.item_name_ref = 16'hFFFF;
            r.game_name_ref = 16'h0;
         end
         if (i == 2) begin
            r.item_name_ref = 16'h0;
            r.game_name_ref = 16'hFFFF;
         end
         pending_reqs.push_back(r);
      end
      pending_reqs.push_back(make_req(REQ_ADD, 32'd95, 4'd0));
      pending_reqs.push_back(make_req(REQ_READ, 32'h0, 4'd15));
      pending_reqs.push_back(make_req(REQ_SORT, 32'h0, 4'd0));
      pending_reqs.push_back(make_req(REQ_READ, 32'h0, 4'd0));
      pending_reqs.push_back(make_req(REQ_DELETE, 32'hFFFF_FFFF, 4'd0));
      pending_reqs.push_back(make_req(REQ_READ, 32'h0, 4'd15));

      // long receiver stall while the sender keeps offering
      hold_off = 200;
      while (pending_reqs.size() > 0 || req_tvalid) @(posedge clock);

      // sender pause until everything has come back
      drain_pause = 1'b1;
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (3) @(posedge clock);
      drain_pause = 1'b0;

      // random part: small key pools so dups and deletes happen, with sorts and reads mixed in
      for (int n = 0; n < 1050; n++) begin
         int roll;
         int pool;
         pool = (n < 500) ? 40 : 12;
         roll = $urandom_range(0, 99);
         if (roll < 40) r = make_req(REQ_ADD, pick_key(pool), 4'd0);
         else if (roll < 65) r = make_req(REQ_DELETE, pick_key(pool), 4'd0);
         else if (roll < 70) r = make_req(REQ_SORT, $urandom, 4'($urandom));
         else r = make_req(REQ_READ, $urandom, 4'($urandom_range(0, 15)));
         if (r.req_type == REQ_ADD) added_keys.push_back(r.item_key);
         if (added_keys.size() > 30) void'(added_keys.pop_front());
         pending_reqs.push_back(r);
         if (n == 600) begin
            while (pending_reqs.size() > 0 || req_tvalid) @(posedge clock);
            hold_off = 150;
         end
      end
      while (pending_reqs.size() > 0 || req_tvalid) @(posedge clock);

      wait_cycles = 0;
      while (expected_rsps.size() > 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      stim_done = 1'b1;
      repeat (700) @(posedge clock);
      if (expected_rsps.size() > 0)
         report_mismatch("items never came back", expected_rsps.size(), 0);
      $display("checked %0d items: added %0d dup %0d full %0d deleted %0d missing %0d",
               rsp_total, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3], status_seen[4]);
      $display("sorted %0d, reads in range %0d, reads past the end %0d",
               status_seen[5], status_seen[6], status_seen[7]);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
